[src/rcs_pkg.sv]
package rcs_pkg;

  // Table depth and derived index widths
  localparam int MAX_CODES = 256;
  localparam int IDX_W     = $clog2(MAX_CODES);
  localparam int CNT_W     = IDX_W + 1;

  // Draw word layout
  localparam int RAND_W     = 31;
  localparam int RAND_SHIFT = 8;
  localparam int DIV_W      = RAND_W - RAND_SHIFT;
  localparam int STEP_W     = $clog2(DIV_W);

  localparam int CODE_W = 8;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_CODES);

  // Request kinds
  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_DRAW    = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [RAND_W-1:0] rand_value;
  } rcs_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              exhausted;
  } rcs_out_t;

endpackage

[src/random_code_shuffle_top.sv]
// Channel   Handshake                Payload           Direction
// request   start / busy             req (rcs_in_t)    in
// result    done (one-cycle strobe)  rsp (rcs_out_t)   out
// config    cfg_valid / cfg_ready    cfg_data[8:0]     in
//
// A restart fills the code table one entry per cycle up to the clamped count.
// A draw runs a restoring modulo one quotient bit per cycle (23 steps), then
// a read-swap-write on the table (RD_SLOT, RD_LAST, WR_SLOT, WR_LAST); a
// draw with nothing left answers straight from idle.
// Synchronous active-high reset clears the control state; the table itself
// is undefined until a restart writes it. The result strobe cannot be held
// off, and busy stays high until the item's work is done.
module random_code_shuffle_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  rcs_pkg::rcs_in_t             req,
  output logic                         done,
  output rcs_pkg::rcs_out_t            rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rcs_pkg::CNT_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_DIV,
    S_RD_SLOT,
    S_RD_LAST,
    S_WR_SLOT,
    S_WR_LAST
  } state_t;

  state_t                          state;
  logic [rcs_pkg::CNT_W-1:0]       code_count;
  logic [rcs_pkg::CNT_W-1:0]       remaining;
  logic [rcs_pkg::CNT_W-1:0]       fill_cnt;
  logic [rcs_pkg::DIV_W-1:0]       div_word;
  logic [rcs_pkg::CNT_W-1:0]       rem_part;
  logic [rcs_pkg::STEP_W-1:0]      step;
  logic [rcs_pkg::IDX_W-1:0]       slot;
  logic [rcs_pkg::CODE_W-1:0]      dealt;

  logic [rcs_pkg::CODE_W-1:0]      mem [rcs_pkg::MAX_CODES];
  logic [rcs_pkg::CODE_W-1:0]      rd_data;
  logic [rcs_pkg::IDX_W-1:0]       rd_addr;
  logic [rcs_pkg::IDX_W-1:0]       wr_addr;
  logic [rcs_pkg::CODE_W-1:0]      wr_data;
  logic                            wr_en;

  logic                            accept;
  logic [rcs_pkg::CNT_W-1:0]       clamped;
  logic [rcs_pkg::IDX_W-1:0]       last;
  logic [rcs_pkg::CNT_W:0]         shifted;
  logic [rcs_pkg::CNT_W:0]         divisor;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign clamped   = (code_count > rcs_pkg::COUNT_RESET) ? rcs_pkg::COUNT_RESET : code_count;
  assign last      = rcs_pkg::IDX_W'(remaining - 1'b1);

  // Modulo step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_part, div_word[rcs_pkg::DIV_W-1]};
  assign divisor = {1'b0, remaining};

  // Table port control
  always_comb begin
    rd_addr = slot;
    wr_addr = slot;
    wr_data = rd_data;
    wr_en   = 1'b0;
    unique case (state)
      S_FILL: begin
        wr_addr = fill_cnt[rcs_pkg::IDX_W-1:0];
        wr_data = rcs_pkg::CODE_W'(fill_cnt[rcs_pkg::IDX_W-1:0]);
        wr_en   = 1'b1;
      end
      S_RD_LAST: begin
        rd_addr = last;
      end
      S_WR_SLOT: begin
        wr_addr = slot;
        wr_data = rd_data;
        wr_en   = 1'b1;
      end
      S_WR_LAST: begin
        wr_addr = last;
        wr_data = dealt;
        wr_en   = 1'b1;
      end
      default: begin
        rd_addr = slot;
      end
    endcase
  end

  // Code table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_count <= rcs_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      code_count <= cfg_data;
    end
  end

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      remaining <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.req_type == rcs_pkg::REQ_RESTART) begin
              remaining <= clamped;
              fill_cnt  <= '0;
              if (clamped != '0) begin
                state <= S_FILL;
              end
            end else if (remaining == '0) begin
              // nothing left to deal
              done          <= 1'b1;
              rsp.code      <= '0;
              rsp.exhausted <= 1'b1;
            end else begin
              div_word <= req.rand_value[rcs_pkg::RAND_W-1:rcs_pkg::RAND_SHIFT];
              rem_part <= '0;
              step     <= '0;
              state    <= S_DIV;
            end
          end
        end
        S_FILL: begin
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt + 1'b1 == remaining) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (shifted >= divisor) begin
            rem_part <= rcs_pkg::CNT_W'(shifted - divisor);
          end else begin
            rem_part <= rcs_pkg::CNT_W'(shifted);
          end
          div_word <= div_word << 1;
          step     <= step + 1'b1;
          if (step == rcs_pkg::STEP_W'(rcs_pkg::DIV_W - 1)) begin
            state <= S_RD_SLOT;
          end
        end
        S_RD_SLOT: begin
          state <= S_RD_LAST;
        end
        S_RD_LAST: begin
          dealt <= rd_data;
          state <= S_WR_SLOT;
        end
        S_WR_SLOT: begin
          state <= S_WR_LAST;
        end
        S_WR_LAST: begin
          remaining     <= remaining - 1'b1;
          done          <= 1'b1;
          rsp.code      <= dealt;
          rsp.exhausted <= 1'b0;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Slot comes from the final remainder, which is below the live count
  assign slot = rem_part[rcs_pkg::IDX_W-1:0];

  // A result is only ever flagged while the block is idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An exhausted draw deals code zero
  a_exh_code: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.exhausted) |-> (rsp.code == '0))
    else $error("exhausted result with nonzero code");

  // The live count never exceeds the table depth
  a_rem_max: assert property (@(posedge clk) disable iff (rst)
    remaining <= rcs_pkg::COUNT_RESET)
    else $error("remaining count above table depth");

  // A restart produces no result
  a_restart_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == rcs_pkg::REQ_RESTART) |=> !done)
    else $error("result after restart");

endmodule
